// File: rtl/delta_field_bit_encoder_macros.svh
`ifndef DELTA_FIELD_BIT_ENCODER_MACROS_SVH
`define DELTA_FIELD_BIT_ENCODER_MACROS_SVH

// same-cycle implication check
`define DFBE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfbe same-cycle check failed");

// next-cycle implication check
`define DFBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfbe next-cycle check failed");

`endif

// File: rtl/dfbe_pkg.sv
package dfbe_pkg;

   localparam int WORD_W = 32;
   localparam int CODE_W = 35;
   localparam int LEN_W  = 6;
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [IDX_W-1:0] CSR_FIELD_BITS = 3'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_RANGE  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_SCALE_M    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_OFFSET_C   = 3'd4;
   localparam logic [IDX_W-1:0] CSR_ZERO_FLAG  = 3'd5;
   localparam logic [IDX_W-1:0] CSR_XOR        = 3'd6;

   localparam logic [2:0] MODE_IGNORE   = 3'd0;
   localparam logic [2:0] MODE_FULL     = 3'd1;
   localparam logic [2:0] MODE_RANGED   = 3'd2;
   localparam logic [2:0] MODE_STRICT   = 3'd3;
   localparam logic [2:0] MODE_UNSIGNED = 3'd4;
   localparam logic [2:0] MODE_SIGNED   = 3'd5;

   localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
   localparam logic [31:0] FLOAT_NAN = 32'h7FC0_0000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [5:0]  field_bits;
      logic [22:0] max_range;
      logic [31:0] scale_m;
      logic [31:0] offset_c;
      logic        zero_flag_enable;
      logic        xor_enable;
   } cfg_type;

   typedef struct packed {
      logic [47:0] prod;
      logic [9:0]  esum;
      logic        sign;
      logic        nan;
      logic        inf;
   } mul_type;

   typedef struct packed {
      logic [27:0] sum;
      logic [7:0]  ebig;
      logic        sign;
      logic        nan;
      logic        inf;
      logic        inf_sign;
   } add_type;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            n = 6'(47 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      n = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            n = 5'(27 - i);
         end
      end
      return n;
   endfunction

   // mn normalized with leading one at bit 47, be is the biased exponent
   function automatic logic [31:0] round_pack(input logic s, input logic [47:0] mn,
                                              input logic signed [10:0] be);
      logic [5:0]  k;
      logic [7:0]  ef;
      logic [47:0] sh;
      logic [47:0] lmask;
      logic        lost;
      logic        inc;
      logic [30:0] fld;
      if (be >= 11'sd255) begin
         return {s, 8'hFF, 23'd0};
      end
      if (be >= 11'sd1) begin
         k  = 6'd0;
         ef = be[7:0];
      end else begin
         ef = 8'd0;
         k  = (be < -11'sd46) ? 6'd48 : 6'(11'sd1 - be);
      end
      sh    = mn >> k;
      lmask = ~(48'hFFFF_FFFF_FFFF << k);
      lost  = |(mn & lmask);
      inc   = sh[23] & ((|sh[22:0]) | lost | sh[24]);
      fld   = {ef, sh[46:24]} + 31'(inc);
      return {s, fld};
   endfunction

   function automatic logic [31:0] float_to_uint(input logic [31:0] w);
      logic [7:0]  e;
      logic [63:0] m;
      e = w[30:23];
      m = {40'd0, 1'b1, w[22:0]};
      if (e == 8'hFF && w[22:0] != 23'd0) begin
         return 32'd0;
      end
      if (w[31]) begin
         return 32'd0;
      end
      if (e >= 8'd159) begin
         return 32'hFFFF_FFFF;
      end
      if (e < 8'd127) begin
         return 32'd0;
      end
      if (e >= 8'd150) begin
         return 32'(m << (e - 8'd150));
      end
      return 32'(m >> (8'd150 - e));
   endfunction

endpackage

// File: rtl/dfbe_req_if.sv
interface dfbe_req_if
   import dfbe_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] base_value;
   logic [WORD_W-1:0] target_value;

   modport source(output valid, output base_value, output target_value, input ready);
   modport sink(input valid, input base_value, input target_value, output ready);
endinterface

// File: rtl/dfbe_rsp_if.sv
interface dfbe_rsp_if
   import dfbe_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_word;
   logic [LEN_W-1:0]  code_length;

   modport source(output valid, output code_word, output code_length, input ready);
   modport sink(input valid, input code_word, input code_length, output ready);
endinterface

// File: rtl/dfbe_scale.sv
module dfbe_scale
   import dfbe_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  logic [WORD_W-1:0] word,
   input  logic [31:0]       scale_m,
   input  logic [31:0]       offset_c,
   output logic [WORD_W-1:0] scaled
);

   mul_type     mul_ff, mul_in;
   logic [31:0] prod_ff, prod_in;
   add_type     add_ff, add_in;

   // stage 1: mantissa product
   always_comb begin
      logic [7:0]  ea, eb;
      logic [23:0] ma, mb;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      ea     = word[30:23];
      eb     = scale_m[30:23];
      ma     = {ea != 8'd0, word[22:0]};
      mb     = {eb != 8'd0, scale_m[22:0]};
      nan_a  = (ea == 8'hFF) && (word[22:0] != 23'd0);
      nan_b  = (eb == 8'hFF) && (scale_m[22:0] != 23'd0);
      inf_a  = (ea == 8'hFF) && (word[22:0] == 23'd0);
      inf_b  = (eb == 8'hFF) && (scale_m[22:0] == 23'd0);
      zero_a = (word[30:0] == 31'd0);
      zero_b = (scale_m[30:0] == 31'd0);
      mul_in.prod = 48'(ma) * 48'(mb);
      mul_in.esum = 10'((ea == 8'd0) ? 8'd1 : ea) + 10'((eb == 8'd0) ? 8'd1 : eb);
      mul_in.sign = word[31] ^ scale_m[31];
      mul_in.nan  = nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
      mul_in.inf  = inf_a | inf_b;
   end

   // stage 2: round product to single
   always_comb begin
      logic [5:0]         lz;
      logic [47:0]        mn;
      logic signed [10:0] be;
      lz = lzc48(mul_ff.prod);
      mn = mul_ff.prod << lz;
      be = $signed(11'(mul_ff.esum)) - 11'sd126 - $signed(11'(lz));
      if (mul_ff.nan) begin
         prod_in = FLOAT_NAN;
      end else if (mul_ff.inf) begin
         prod_in = {mul_ff.sign, 8'hFF, 23'd0};
      end else if (mul_ff.prod == 48'd0) begin
         prod_in = {mul_ff.sign, 31'd0};
      end else begin
         prod_in = round_pack(mul_ff.sign, mn, be);
      end
   end

   // stage 3: align and add offset
   always_comb begin
      logic [7:0]  ep, ec, ebig, esml, d;
      logic [23:0] mp, mc, mbig, msml;
      logic        nan_p, nan_c, inf_p, inf_c, p_big, sub;
      logic [26:0] big27, sml27, sh, shf;
      logic        stk;
      nan_p = (prod_ff[30:23] == 8'hFF) && (prod_ff[22:0] != 23'd0);
      nan_c = (offset_c[30:23] == 8'hFF) && (offset_c[22:0] != 23'd0);
      inf_p = (prod_ff[30:23] == 8'hFF) && (prod_ff[22:0] == 23'd0);
      inf_c = (offset_c[30:23] == 8'hFF) && (offset_c[22:0] == 23'd0);
      ep    = (prod_ff[30:23] == 8'd0) ? 8'd1 : prod_ff[30:23];
      ec    = (offset_c[30:23] == 8'd0) ? 8'd1 : offset_c[30:23];
      mp    = {prod_ff[30:23] != 8'd0, prod_ff[22:0]};
      mc    = {offset_c[30:23] != 8'd0, offset_c[22:0]};
      p_big = {ep, mp} >= {ec, mc};
      ebig  = p_big ? ep : ec;
      esml  = p_big ? ec : ep;
      mbig  = p_big ? mp : mc;
      msml  = p_big ? mc : mp;
      sub   = prod_ff[31] ^ offset_c[31];
      d     = ebig - esml;
      big27 = {mbig, 3'd0};
      sml27 = {msml, 3'd0};
      sh    = sml27 >> d;
      stk   = |(sml27 & ~(27'h7FF_FFFF << d));
      shf   = {sh[26:1], sh[0] | stk};
      add_in.sum      = sub ? ({1'b0, big27} - {1'b0, shf}) : ({1'b0, big27} + {1'b0, shf});
      add_in.ebig     = ebig;
      add_in.sign     = p_big ? prod_ff[31] : offset_c[31];
      add_in.nan      = nan_p | nan_c | (inf_p & inf_c & sub);
      add_in.inf      = inf_p | inf_c;
      add_in.inf_sign = inf_p ? prod_ff[31] : offset_c[31];
   end

   // stage 4: normalize, round, truncate to unsigned
   always_comb begin
      logic [4:0]         lz;
      logic [47:0]        mn;
      logic signed [10:0] be;
      logic [31:0]        r;
      lz = lzc28(add_ff.sum);
      mn = {add_ff.sum << lz, 20'd0};
      be = $signed(11'(add_ff.ebig)) + 11'sd1 - $signed(11'(lz));
      if (add_ff.nan) begin
         r = FLOAT_NAN;
      end else if (add_ff.inf) begin
         r = {add_ff.inf_sign, 8'hFF, 23'd0};
      end else if (add_ff.sum == 28'd0) begin
         r = 32'd0;
      end else begin
         r = round_pack(add_ff.sign, mn, be);
      end
      scaled = float_to_uint(r);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff  <= mul_in;
         prod_ff <= prod_in;
         add_ff  <= add_in;
      end
   end

endmodule

// File: rtl/dfbe_pack.sv
module dfbe_pack
   import dfbe_pkg::*;
(
   input  cfg_type           cfg,
   input  logic [WORD_W-1:0] base_value,
   input  logic [WORD_W-1:0] target_value,
   input  logic [WORD_W-1:0] base_scaled,
   input  logic [WORD_W-1:0] target_scaled,
   output logic [CODE_W-1:0] code_word,
   output logic [LEN_W-1:0]  code_length
);

   always_comb begin
      logic [5:0]  nb, w, pre;
      logic [31:0] val, mask_nb, mask_w, mag, iv;
      logic [7:0]  e;
      logic [4:0]  rs;
      logic [23:0] sig;
      logic        short_form;
      nb      = (cfg.field_bits > 6'd32) ? 6'd32 : cfg.field_bits;
      mask_nb = ~(32'hFFFF_FFFF << nb);
      pre     = cfg.zero_flag_enable ? 6'd2 : 6'd1;
      e       = target_value[30:23];
      sig     = {1'b1, target_value[22:0]};
      rs      = 5'(8'd150 - e);
      mag     = 32'd0;
      short_form = 1'b0;
      if (target_value[30:0] == 31'd0) begin
         short_form = 1'b1;
      end else if (e >= 8'd127 && e <= 8'd150) begin
         mag = 32'(sig >> rs);
         short_form = ((sig & ~(24'hFF_FFFF << rs)) == 24'd0) &&
                      (mag <= 32'(cfg.max_range));
      end
      iv = target_value[31] ? (32'd0 - mag) : mag;
      w  = (cfg.mode == MODE_FULL) ? 6'd32 : nb;
      mask_w = ~(32'hFFFF_FFFF << w);
      if (cfg.mode == MODE_STRICT) begin
         val = cfg.xor_enable ? (base_scaled ^ target_scaled) : target_scaled;
      end else begin
         val = cfg.xor_enable ? (base_value ^ target_value) : target_value;
      end
      if (base_value == target_value) begin
         code_word   = 35'd1;
         code_length = 6'd1;
      end else if (cfg.zero_flag_enable && target_value == 32'd0) begin
         code_word   = 35'd1;
         code_length = 6'd2;
      end else if (cfg.mode == MODE_RANGED) begin
         if (short_form) begin
            code_word   = 35'(iv & mask_nb);
            code_length = pre + 6'd1 + nb;
         end else begin
            code_word   = {2'b0, 1'b1, target_value};
            code_length = pre + 6'd33;
         end
      end else begin
         code_word   = 35'(val & mask_w);
         code_length = pre + w;
      end
   end

endmodule

// File: rtl/delta_field_bit_encoder.sv
// Delta field bit encoder.
// req_ch carries a base word and a target word; rsp_ch returns one code word
// (right-aligned, first bit at code_length-1) and its length for every
// transfer on req_ch. Both are valid/ready channels.
// csr_we/csr_index/csr_data write the mode and field registers; write them
// only while no transfer is in flight.
// A req_ch transfer reaches rsp_ch.valid through the registers of the
// scaled-float path (input register, multiply, product rounding, offset
// add, final rounding into the output register).
// Throughput: one transfer per cycle while rsp_ch is taken every cycle.
// When rsp_ch stalls, the whole pipeline holds and req_ch.ready drops until
// the output register is taken.
// Reset (synchronous, active high) empties the pipeline and loads register
// defaults: mode unsigned, field bits 0, scale 1.0, offset 0, flags off.
`include "delta_field_bit_encoder_macros.svh"

module delta_field_bit_encoder
   import dfbe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dfbe_req_if.sink          req_ch,
   dfbe_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [WORD_W-1:0] csr_data
);

   cfg_type           cfg_ff, cfg_in;
   logic [3:0]        vld_ff, vld_in;
   logic              out_vld_ff, out_vld_in;
   logic [WORD_W-1:0] base_ff [4];
   logic [WORD_W-1:0] target_ff [4];
   logic [WORD_W-1:0] base_scaled, target_scaled;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              advance;

   assign advance      = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:       cfg_in.mode             = csr_data[2:0];
            CSR_FIELD_BITS: cfg_in.field_bits       = csr_data[5:0];
            CSR_MAX_RANGE:  cfg_in.max_range        = csr_data[22:0];
            CSR_SCALE_M:    cfg_in.scale_m          = csr_data;
            CSR_OFFSET_C:   cfg_in.offset_c         = csr_data;
            CSR_ZERO_FLAG:  cfg_in.zero_flag_enable = csr_data[0];
            CSR_XOR:        cfg_in.xor_enable       = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign vld_in     = {vld_ff[2:0], req_ch.valid};
   assign out_vld_in = vld_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_UNSIGNED, field_bits: 6'd0, max_range: 23'd0,
                     scale_m: FLOAT_ONE, offset_c: 32'd0,
                     zero_flag_enable: 1'b0, xor_enable: 1'b0};
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            vld_ff     <= vld_in;
            out_vld_ff <= out_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         base_ff[0]   <= req_ch.base_value;
         target_ff[0] <= req_ch.target_value;
         for (int i = 1; i < 4; i++) begin
            base_ff[i]   <= base_ff[i-1];
            target_ff[i] <= target_ff[i-1];
         end
         code_ff <= code_in;
         len_ff  <= len_in;
      end
   end

   dfbe_scale u_scale_base (
      .clock    (clock),
      .advance  (advance),
      .word     (base_ff[0]),
      .scale_m  (cfg_ff.scale_m),
      .offset_c (cfg_ff.offset_c),
      .scaled   (base_scaled)
   );

   dfbe_scale u_scale_target (
      .clock    (clock),
      .advance  (advance),
      .word     (target_ff[0]),
      .scale_m  (cfg_ff.scale_m),
      .offset_c (cfg_ff.offset_c),
      .scaled   (target_scaled)
   );

   dfbe_pack u_pack (
      .cfg           (cfg_ff),
      .base_value    (base_ff[3]),
      .target_value  (target_ff[3]),
      .base_scaled   (base_scaled),
      .target_scaled (target_scaled),
      .code_word     (code_in),
      .code_length   (len_in)
   );

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.code_word   = code_ff;
   assign rsp_ch.code_length = len_ff;

   `DFBE_ASSERT_IMPLY(a_len_range, clock, reset, out_vld_ff,
                      len_ff >= 6'd1 && len_ff <= 6'd35)
   `DFBE_ASSERT_IMPLY(a_code_fits, clock, reset, out_vld_ff,
                      (code_ff >> len_ff) == 35'd0)
   `DFBE_ASSERT_NEXT(a_take_fills, clock, reset, req_ch.valid && req_ch.ready,
                     vld_ff[0])
   `DFBE_ASSERT_NEXT(a_stall_hold, clock, reset, out_vld_ff && !rsp_ch.ready,
                     $stable(vld_ff) && $stable(code_ff))

endmodule
